// File: rtl/isort_pkg.sv
// isort_pkg: shared types and constants for the insertion sorter
// no dependencies; used by the interfaces and every module of the block
`timescale 1ns / 1ps

package isort_pkg;

  // number of cells in the sorted store
  localparam int CAPACITY = 64;
  // fill count must hold the value CAPACITY itself
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic signed [31:0] value_t;
  typedef logic [CNT_W-1:0]   count_t;

  typedef enum logic [0:0] {
    ST_COLLECT,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic insert;  // write the accepted word into the store
    logic drop;    // accepted word finds the store full
    logic emit;    // load the output register and shift the store down
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;      // no room for another word
    logic one_left;  // a single entry remains to be emitted
  } status_t;

endpackage

// File: rtl/isort_if.sv
// isort_if: valid/ready channels for input words and sorted results
// depends on isort_pkg
`timescale 1ns / 1ps

interface isort_in_if;
  import isort_pkg::*;

  logic   valid;
  logic   ready;
  value_t value;
  logic   last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface isort_out_if;
  import isort_pkg::*;

  logic   valid;
  logic   ready;
  value_t sorted_value;
  logic   last_out;
  logic   dropped;

  modport source (output valid, output sorted_value, output last_out,
                  output dropped, input ready);
  modport sink   (input valid, input sorted_value, input last_out,
                  input dropped, output ready);
endinterface

// File: rtl/insertion_sorter.sv
// insertion_sorter: top level, joins the controller and the cell datapath
// depends on isort_pkg, isort_if, isort_ctrl, isort_dp
//
//   channel   dir  payload                              handshake
//   items     in   value[31:0] signed, last             valid/ready
//   results   out  sorted_value[31:0] signed,           valid/ready
//                  last_out, dropped
//
// one input word is inserted per cycle while collecting and the store is not full:
// every cell compares in parallel; a batch of n stored words drains one word per cycle
// from cell zero, and items.ready stays low until the batch has drained
// results back-pressure stalls the drain; the output register holds a word
// while the next batch is collected
// synchronous reset clears the state, output valid flag, fill count and overflow flag only
`timescale 1ns / 1ps

module insertion_sorter (
  input  logic        clk,
  input  logic        rst,
  isort_in_if.sink    items,
  isort_out_if.source results
);
  import isort_pkg::*;

  cmd_t    cmd;
  status_t status;

  // control
  isort_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_last   (items.last),
    .in_ready  (items.ready),
    .out_ready (results.ready),
    .out_valid (results.valid),
    .status    (status),
    .cmd       (cmd)
  );

  // cells and output register
  isort_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .value        (items.value),
    .sorted_value (results.sorted_value),
    .last_out     (results.last_out),
    .dropped      (results.dropped)
  );

endmodule

// File: rtl/isort_ctrl.sv
// isort_ctrl: state machine that sequences collection and emission
// depends on isort_pkg; drives the datapath through cmd_t, reads status_t
`timescale 1ns / 1ps

module isort_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  input  isort_pkg::status_t  status,
  output isort_pkg::cmd_t     cmd
);
  import isort_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   accept;
  logic   emit_go;

  // handshake terms
  assign accept  = in_ready && in_valid;
  assign emit_go = !out_valid || out_ready;

  // state register and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_COLLECT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_COLLECT: begin
        if (accept && in_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go && status.one_left) begin
          state_next = ST_COLLECT;
        end
      end
      default: state_next = ST_COLLECT;
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    in_ready   = 1'b0;
    cmd.insert = 1'b0;
    cmd.drop   = 1'b0;
    cmd.emit   = 1'b0;
    case (state)
      ST_COLLECT: begin
        in_ready   = 1'b1;
        cmd.insert = accept && !status.full;
        cmd.drop   = accept && status.full;
      end
      ST_EMIT: begin
        cmd.emit = emit_go;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // output register holds a word until taken
  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// File: rtl/isort_dp.sv
// isort_dp: row of compare-and-shift cells, fill count, overflow flag
// and output register; depends on isort_pkg, driven by isort_ctrl
`timescale 1ns / 1ps

module isort_dp (
  input  logic                clk,
  input  logic                rst,
  input  isort_pkg::cmd_t     cmd,
  output isort_pkg::status_t  status,
  input  isort_pkg::value_t   value,
  output isort_pkg::value_t   sorted_value,
  output logic                last_out,
  output logic                dropped
);
  import isort_pkg::*;

  value_t cells [CAPACITY];
  logic   gt    [CAPACITY];
  count_t fill_count;
  logic   overflow_seen;

  // per cell: entry is empty or strictly greater than the new word,
  // so equal values keep their order of arrival
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      gt[i] = (count_t'(i) >= fill_count) || (cells[i] > value);
    end
  end

  // cells: insert in place or shift toward cell zero when emitting
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (gt[0]) begin
        cells[0] <= value;
      end
      for (int i = 1; i < CAPACITY; i++) begin
        if (gt[i]) begin
          if (gt[i-1]) begin
            cells[i] <= cells[i-1];
          end else begin
            cells[i] <= value;
          end
        end
      end
    end else if (cmd.emit) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        cells[i] <= cells[i+1];
      end
    end
  end

  // fill count and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (cmd.insert) begin
        fill_count <= fill_count + count_t'(1);
      end else if (cmd.emit) begin
        fill_count <= fill_count - count_t'(1);
      end
      if (cmd.drop) begin
        overflow_seen <= 1'b1;
      end else if (cmd.emit && status.one_left) begin
        overflow_seen <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sorted_value <= cells[0];
      last_out     <= status.one_left;
      dropped      <= overflow_seen;
    end
  end

  assign status.full     = (fill_count == count_t'(CAPACITY));
  assign status.one_left = (fill_count == count_t'(1));

endmodule

// File: verif/insertion_sorter_test.sv
// insertion_sorter_test: self-checking bench for the batch insertion sorter
// depends on isort_pkg, isort_if and insertion_sorter from the rtl folder
`timescale 1ns / 1ps

module insertion_sorter_test;
  import isort_pkg::*;

  typedef struct {
    value_t sorted_value;
    logic   last_out;
    logic   dropped;
  } sorted_word_t;

  // one row of the directed table; typed rows are single-word batches
  typedef struct {
    value_t value;
    logic   last;
    logic   typed;
    value_t sole_value;
  } stim_row_t;

  localparam value_t VMAX = 32'sh7fffffff;
  localparam value_t VMIN = 32'sh80000000;
  localparam int     RANDOM_WORDS = 180;
  localparam int     NUM_ROWS = 24;

  logic clk;
  logic rst;

  isort_in_if  items ();
  isort_out_if results ();

  insertion_sorter dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .results (results)
  );

  // shadow copy of the sorted store
  value_t       shadow_store[$];
  logic         shadow_overflow;
  sorted_word_t batch_out[$];
  sorted_word_t expected_words[$];

  int  mismatches;
  int  words_sent;
  int  words_checked;
  int  batches_sent;
  int  overflow_batches;
  bit  calm;

  stim_row_t directed_rows[NUM_ROWS] = '{
    '{VMAX, 1'b1, 1'b1, VMAX},
    '{VMIN, 1'b1, 1'b1, VMIN},
    '{32'sd0, 1'b1, 1'b1, 32'sd0},
    '{-32'sd1, 1'b1, 1'b1, -32'sd1},
    '{32'sd5, 1'b0, 1'b0, 32'sd0},
    '{-32'sd5, 1'b0, 1'b0, 32'sd0},
    '{32'sd5, 1'b0, 1'b0, 32'sd0},
    '{32'sd0, 1'b1, 1'b0, 32'sd0},
    '{VMAX, 1'b0, 1'b0, 32'sd0},
    '{32'sd100, 1'b0, 1'b0, 32'sd0},
    '{-32'sd100, 1'b0, 1'b0, 32'sd0},
    '{VMIN, 1'b1, 1'b0, 32'sd0},
    '{VMIN, 1'b0, 1'b0, 32'sd0},
    '{-32'sd1, 1'b0, 1'b0, 32'sd0},
    '{32'sd0, 1'b0, 1'b0, 32'sd0},
    '{VMAX, 1'b1, 1'b0, 32'sd0},
    '{32'sd7, 1'b0, 1'b0, 32'sd0},
    '{32'sd7, 1'b0, 1'b0, 32'sd0},
    '{32'sd7, 1'b0, 1'b0, 32'sd0},
    '{32'sd7, 1'b1, 1'b0, 32'sd0},
    '{32'shaaaaaaaa, 1'b0, 1'b0, 32'sd0},
    '{32'sh55555555, 1'b0, 1'b0, 32'sd0},
    '{32'sh80000001, 1'b1, 1'b0, 32'sd0},
    '{32'sd1, 1'b1, 1'b1, 32'sd1}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // insert one word into the shadow store; a last word drains it into batch_out
  function automatic void sort_word(value_t v, logic is_last);
    int pos;
    pos = 0;
    batch_out.delete();
    if (shadow_store.size() < CAPACITY) begin
      // equal values keep arrival order: go past every stored value <= v
      while (pos < shadow_store.size() && shadow_store[pos] <= v) pos++;
      shadow_store.insert(pos, v);
    end else begin
      shadow_overflow = 1'b1;
    end
    if (is_last) begin
      foreach (shadow_store[k])
        batch_out.push_back('{shadow_store[k], logic'(k == shadow_store.size() - 1),
                              shadow_overflow});
      if (shadow_overflow) overflow_batches++;
      shadow_store.delete();
      shadow_overflow = 1'b0;
    end
  endfunction

  // mix of extremes, a narrow band for duplicates, and full-range words
  function automatic value_t pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return VMIN;
      1: return VMAX;
      2, 3, 4: return value_t'($signed($urandom_range(0, 8)) - 4);
      default: return value_t'($urandom);
    endcase
  endfunction

  function automatic int draw_gap();
    if (calm) return 0;
    return $urandom_range(0, 19);
  endfunction

  // drive one word; entered and left at a falling edge
  task automatic send_word(value_t v, logic is_last, logic typed, value_t sole_value);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      items.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    items.valid <= 1'b1;
    items.value <= v;
    items.last  <= is_last;
    do @(posedge clk); while (!items.ready);
    sort_word(v, is_last);
    words_sent++;
    if (is_last) begin
      batches_sent++;
      if (typed) expected_words.push_back('{sole_value, 1'b1, 1'b0});
      else foreach (batch_out[k]) expected_words.push_back(batch_out[k]);
    end
    @(negedge clk);
  endtask

  // result side: random stalls, compare each accepted word with the oldest expectation
  initial begin
    int           gap;
    sorted_word_t want;
    results.ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        results.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      results.ready <= 1'b1;
      do @(posedge clk); while (!results.valid);
      if (expected_words.size() == 0) begin
        $error("unexpected result word: sorted_value %0d", results.sorted_value);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (results.sorted_value !== want.sorted_value) begin
          $error("sorted_value: expected %0d, got %0d", want.sorted_value,
                 results.sorted_value);
          mismatches++;
        end
        if (results.last_out !== want.last_out) begin
          $error("last_out: expected %0b, got %0b", want.last_out, results.last_out);
          mismatches++;
        end
        if (results.dropped !== want.dropped) begin
          $error("dropped: expected %0b, got %0b", want.dropped, results.dropped);
          mismatches++;
        end
      end
      @(negedge clk);
    end
  end

  // stimulus and end of run
  initial begin
    int random_words;
    int batch_idx;
    int batch_len;
    shadow_overflow  = 1'b0;
    mismatches       = 0;
    words_sent       = 0;
    words_checked    = 0;
    batches_sent     = 0;
    overflow_batches = 0;
    calm             = 1'b0;
    rst              = 1'b1;
    items.valid      = 1'b0;
    items.value      = '0;
    items.last       = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    foreach (directed_rows[r])
      send_word(directed_rows[r].value, directed_rows[r].last, directed_rows[r].typed,
                directed_rows[r].sole_value);

    // random batches; two of them fill the store exactly and past capacity
    random_words = 0;
    batch_idx    = 0;
    while (random_words < RANDOM_WORDS) begin
      if (batch_idx == 2)      batch_len = CAPACITY;
      else if (batch_idx == 5) batch_len = CAPACITY + 2;
      else                     batch_len = $urandom_range(1, 12);
      calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < batch_len; k++)
        send_word(pick_value(), logic'(k == batch_len - 1), 1'b0, 32'sd0);
      random_words += batch_len;
      batch_idx++;
    end
    calm = 1'b0;
    items.valid <= 1'b0;

    // drain the expectations, then keep watching for unexpected result words
    while (expected_words.size() > 0) @(posedge clk);
    repeat (CAPACITY + 20) @(posedge clk);

    $display("run covered %0d words in %0d batches, %0d sorted words checked",
             words_sent, batches_sent, words_checked);
    $display("%0d batches overflowed the store", overflow_batches);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(100_000 * 20);
    $display("timeout: %0d words still expected", expected_words.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: filelist.f
rtl/isort_pkg.sv
rtl/isort_if.sv
rtl/isort_ctrl.sv
rtl/isort_dp.sv
rtl/insertion_sorter.sv
verif/insertion_sorter_test.sv
